@@ hdl/alm_pkg.sv @@
// Shared types and constants of the multichannel audio level meter.
package alm_pkg;

  localparam int OPCODE_W  = 2;
  localparam int CHANNEL_W = 6;
  localparam int TICKF_W   = 13;
  localparam int LEVEL_W   = 24;
  localparam int ENERGY_W  = 64;
  localparam int COUNT_W   = 32;
  localparam int TICKS_W   = 32;
  localparam int FTOTAL_W  = 48;
  localparam int ROOT_W    = 32;
  localparam int STEP_W    = 6;

  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd3;

  localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;
  localparam logic [STEP_W-1:0] ROOT_LAST = 6'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE,
    ST_ROOT_WAIT,
    ST_EMIT
  } alm_state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT,
    RT_DONE
  } root_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

@@ hdl/alm_ifs.sv @@
// Valid/ready channel interfaces for the level meter input and result items.
interface alm_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [alm_pkg::OPCODE_W-1:0]  opcode;
  logic [alm_pkg::CHANNEL_W-1:0] channel;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [alm_pkg::TICKF_W-1:0]   tick_frames;

  modport source (output valid, opcode, channel, sample, tick_frames, input ready);
  modport sink (input valid, opcode, channel, sample, tick_frames, output ready);
endinterface

interface alm_out_if;
  logic                         valid;
  logic                         ready;
  logic [alm_pkg::LEVEL_W-1:0]  peak_level;
  logic [alm_pkg::LEVEL_W-1:0]  rms_level;
  logic [alm_pkg::COUNT_W-1:0]  frames_counted;
  logic                         clip_seen;
  logic [alm_pkg::TICKS_W-1:0]  tick_total;
  logic [alm_pkg::FTOTAL_W-1:0] frame_total;

  modport source (output valid, peak_level, rms_level, frames_counted, clip_seen,
                  tick_total, frame_total, input ready);
  modport sink (input valid, peak_level, rms_level, frames_counted, clip_seen,
                tick_total, frame_total, output ready);
endinterface

@@ hdl/alm_store.sv @@
// Per-channel store memory with registered read and per-entry valid bits.
module alm_store #(
  parameter int DATA_W = 121,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

@@ hdl/alm_root.sv @@
// Iterative unit computing floor(sqrt(energy / count)) by restoring division then digit root.
module alm_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [alm_pkg::ENERGY_W-1:0]  energy,
  input  logic [alm_pkg::COUNT_W-1:0]   count,
  output alm_pkg::root_stat_t           stat,
  output logic [alm_pkg::ROOT_W-1:0]    root
);

  alm_pkg::root_state_t state_r, state_nxt;
  logic [alm_pkg::STEP_W-1:0]   step_r;
  logic [alm_pkg::COUNT_W-1:0]  rem_r, div_r;
  logic [alm_pkg::ENERGY_W-1:0] quo_r, v_r, r_r, bit_r;

  logic [alm_pkg::COUNT_W:0]    rem_s;
  logic                         div_take;
  logic [alm_pkg::COUNT_W-1:0]  rem_nxt;
  logic [alm_pkg::ENERGY_W-1:0] quo_nxt, trial, v_nxt, r_nxt;
  logic                         root_take;

  always_comb begin
    rem_s    = {rem_r, quo_r[alm_pkg::ENERGY_W-1]};
    div_take = rem_s >= {1'b0, div_r};
    rem_nxt  = div_take ? alm_pkg::COUNT_W'(rem_s - {1'b0, div_r})
                        : alm_pkg::COUNT_W'(rem_s);
    quo_nxt  = {quo_r[alm_pkg::ENERGY_W-2:0], div_take};
    trial     = r_r + bit_r;
    root_take = v_r >= trial;
    v_nxt     = root_take ? v_r - trial : v_r;
    r_nxt     = root_take ? (r_r >> 1) + bit_r : r_r >> 1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alm_pkg::RT_IDLE: if (start) state_nxt = alm_pkg::RT_DIV;
      alm_pkg::RT_DIV:  if (step_r == alm_pkg::DIV_LAST) state_nxt = alm_pkg::RT_SQRT;
      alm_pkg::RT_SQRT: if (step_r == alm_pkg::ROOT_LAST) state_nxt = alm_pkg::RT_DONE;
      alm_pkg::RT_DONE: state_nxt = alm_pkg::RT_IDLE;
      default:          state_nxt = alm_pkg::RT_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = state_r != alm_pkg::RT_IDLE;
    stat.done = state_r == alm_pkg::RT_DONE;
  end

  assign root = alm_pkg::ROOT_W'(r_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alm_pkg::RT_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      alm_pkg::RT_IDLE: begin
        quo_r <= energy;
        div_r <= count;
        rem_r <= '0;
      end
      alm_pkg::RT_DIV: begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        if (step_r == alm_pkg::DIV_LAST) begin
          v_r   <= quo_nxt;
          r_r   <= '0;
          bit_r <= alm_pkg::ENERGY_W'(1) << (alm_pkg::ENERGY_W - 2);
        end
      end
      alm_pkg::RT_SQRT: begin
        v_r   <= v_nxt;
        r_r   <= r_nxt;
        bit_r <= bit_r >> 2;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/multichannel_audio_level_meter.sv @@
// Top level of the multichannel audio level meter.
//
// Channel   Dir  Handshake    Item
// in_ch     in   valid/ready  opcode, channel, sample, tick_frames
// out_ch    out  valid/ready  peak, rms, frames, clip, tick and frame totals
//
// Tick and clear items are applied at the accept; a sample goes through memory
// read, square and write back. A read with a root to take goes through the
// accept, a lookup, 64 division steps, 32 root steps and a handoff in the shared
// root unit, then loads the result register; one with no root skips the unit.
// Reset and clear invalidate all channel entries at once through valid bits.
// A read waits in its last state while the previous result is not yet taken.
module multichannel_audio_level_meter #(
  parameter int NUM_CHANNELS = 64,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  alm_in_if.sink   in_ch,
  alm_out_if.source out_ch
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ACT_W  = $clog2(NUM_CHANNELS + 1);
  localparam int ENT_W  = SAMPLE_BITS + alm_pkg::ENERGY_W + alm_pkg::COUNT_W + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS;

  alm_pkg::alm_state_t state_r, state_nxt;

  logic                          in_acc;
  logic [alm_pkg::OPCODE_W-1:0]  op_r;
  logic [IDX_W-1:0]              idx_r;
  logic                          chan_ok, chan_ok_r;
  logic [SAMPLE_BITS-1:0]        mag, mag_r;
  logic [SQ_W-1:0]               sq_r;
  logic [ACT_W-1:0]              active_r;
  logic [alm_pkg::TICKS_W-1:0]   ticks_r;
  logic [alm_pkg::FTOTAL_W-1:0]  ftotal_r;

  logic [ENT_W-1:0]              rd_ent, wr_ent;
  logic [SAMPLE_BITS-1:0]        e_peak;
  logic [alm_pkg::ENERGY_W-1:0]  e_energy;
  logic [alm_pkg::COUNT_W-1:0]   e_count;
  logic                          e_clip;
  logic [alm_pkg::ENERGY_W:0]    e_sum;
  logic [alm_pkg::ENERGY_W-1:0]  n_energy;
  logic [alm_pkg::COUNT_W-1:0]   n_count;
  logic [SAMPLE_BITS-1:0]        n_peak;
  logic                          n_clip;
  logic                          need_root;

  alm_pkg::root_stat_t           root_stat;
  logic [alm_pkg::ROOT_W-1:0]    root;
  logic                          root_start;
  logic [alm_pkg::ROOT_W-1:0]    rms_r;
  logic                          emit_go;
  logic                          clr_go;

  logic                          out_valid_r;
  logic [alm_pkg::LEVEL_W-1:0]   out_peak_r, out_rms_r;
  logic [alm_pkg::COUNT_W-1:0]   out_count_r;
  logic                          out_clip_r;
  logic [alm_pkg::TICKS_W-1:0]   out_ticks_r;
  logic [alm_pkg::FTOTAL_W-1:0]  out_ftotal_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign chan_ok = {24'd0, in_ch.channel} < 30'(NUM_CHANNELS);
  assign mag     = in_ch.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_ch.sample)
                                               : SAMPLE_BITS'(in_ch.sample);
  assign clr_go  = in_acc && in_ch.opcode == alm_pkg::OP_CLEAR;

  assign {e_peak, e_energy, e_count, e_clip} = rd_ent;

  always_comb begin
    e_sum    = {1'b0, e_energy} + (alm_pkg::ENERGY_W + 1)'(sq_r);
    n_energy = e_sum[alm_pkg::ENERGY_W] ? '1 : e_sum[alm_pkg::ENERGY_W-1:0];
    n_count  = (e_count == '1) ? e_count : e_count + 1'b1;
    n_peak   = (mag_r > e_peak) ? mag_r : e_peak;
    n_clip   = e_clip || (mag_r >= (SAMPLE_BITS'(1) << (SAMPLE_BITS - 2)));
    wr_ent   = {n_peak, n_energy, n_count, n_clip};
    need_root = chan_ok_r && (ACT_W + 1)'(idx_r) < {1'b0, active_r} && e_count != '0;
  end

  alm_store #(
    .DATA_W (ENT_W),
    .DEPTH  (NUM_CHANNELS),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr_go),
    .rd_en   (in_acc),
    .rd_addr (IDX_W'(in_ch.channel)),
    .wr_en   (state_r == alm_pkg::ST_UPDATE && chan_ok_r),
    .wr_addr (idx_r),
    .wr_data (wr_ent),
    .rd_data (rd_ent)
  );

  alm_root u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (root_start),
    .energy (e_energy),
    .count  (e_count),
    .stat   (root_stat),
    .root   (root)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alm_pkg::ST_IDLE: begin
        if (in_acc && (in_ch.opcode == alm_pkg::OP_SAMPLE ||
                       in_ch.opcode == alm_pkg::OP_READ)) begin
          state_nxt = alm_pkg::ST_LOOK;
        end
      end
      alm_pkg::ST_LOOK: begin
        if (op_r == alm_pkg::OP_SAMPLE) begin
          state_nxt = alm_pkg::ST_UPDATE;
        end else if (need_root) begin
          state_nxt = alm_pkg::ST_ROOT_WAIT;
        end else begin
          state_nxt = alm_pkg::ST_EMIT;
        end
      end
      alm_pkg::ST_UPDATE:    state_nxt = alm_pkg::ST_IDLE;
      alm_pkg::ST_ROOT_WAIT: if (root_stat.done) state_nxt = alm_pkg::ST_EMIT;
      alm_pkg::ST_EMIT:      if (emit_go) state_nxt = alm_pkg::ST_IDLE;
      default:               state_nxt = alm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = state_r == alm_pkg::ST_IDLE;
    root_start  = state_r == alm_pkg::ST_LOOK && op_r == alm_pkg::OP_READ && need_root;
    emit_go     = state_r == alm_pkg::ST_EMIT && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alm_pkg::ST_IDLE;
      active_r    <= '0;
      ticks_r     <= '0;
      ftotal_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_go) begin
        active_r <= '0;
        ticks_r  <= '0;
        ftotal_r <= '0;
      end else if (in_acc && in_ch.opcode == alm_pkg::OP_TICK) begin
        ticks_r  <= ticks_r + 1'b1;
        ftotal_r <= ftotal_r + alm_pkg::FTOTAL_W'(in_ch.tick_frames);
      end else if (state_r == alm_pkg::ST_UPDATE && chan_ok_r &&
                   ACT_W'(idx_r) >= active_r) begin
        active_r <= ACT_W'(idx_r) + 1'b1;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_ch.opcode;
      idx_r     <= IDX_W'(in_ch.channel);
      chan_ok_r <= chan_ok;
      mag_r     <= mag;
    end
    if (state_r == alm_pkg::ST_LOOK) begin
      sq_r  <= SQ_W'(mag_r * mag_r);
      rms_r <= '0;
    end
    if (root_stat.done) begin
      rms_r <= root;
    end
    if (emit_go) begin
      out_peak_r   <= chan_ok_r ? alm_pkg::LEVEL_W'(e_peak) : '0;
      out_rms_r    <= alm_pkg::LEVEL_W'(rms_r);
      out_count_r  <= chan_ok_r ? e_count : '0;
      out_clip_r   <= chan_ok_r && e_clip;
      out_ticks_r  <= ticks_r;
      out_ftotal_r <= ftotal_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.peak_level     = out_peak_r;
  assign out_ch.rms_level      = out_rms_r;
  assign out_ch.frames_counted = out_count_r;
  assign out_ch.clip_seen      = out_clip_r;
  assign out_ch.tick_total     = out_ticks_r;
  assign out_ch.frame_total    = out_ftotal_r;

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == alm_pkg::ST_EMIT))
    else $error("result appeared outside the emit state");

  a_root_owner: assert property (@(posedge clk) disable iff (!rst_n)
    root_stat.busy |-> state_r == alm_pkg::ST_ROOT_WAIT)
    else $error("root unit busy while the controller is not waiting");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= ACT_W'(NUM_CHANNELS))
    else $error("active channel count out of range");

  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.opcode == alm_pkg::OP_READ) |=> !in_ch.ready)
    else $error("new item taken while a read is in progress");

endmodule
